FILE: design/dynamic_inversion_counter_assert.svh
// ----------------------------------------------------------------------------
// Dynamic inversion counter - assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_INVERSION_COUNTER_ASSERT_SVH
`define DYNAMIC_INVERSION_COUNTER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DIC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every clock edge, reset included.
`define DIC_ASSERT_ALWAYS(lbl, clk, cond, msg) \
    lbl: assert property (@(posedge clk) cond) else $error(msg);

`endif

FILE: design/dic_pkg.sv
// ----------------------------------------------------------------------------
// Dynamic inversion counter - package
// Field widths, register map and item codes shared by the design files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dic_pkg;

    localparam int DefMaxElements = 1024;

    localparam int ValueW = 11;
    localparam int InvW   = 19;
    localparam int TotalW = 20;
    localparam int SizeW  = 11;

    localparam int InDataW  = 16;
    localparam int OutDataW = 24;

    localparam logic [SizeW-1:0] SizeReset = 11'd1024;

    localparam int ApbAddrW = 1;
    localparam logic [ApbAddrW-1:0] RegNSize = 1'b0;

    localparam logic ActLoad   = 1'b0;
    localparam logic ActDelete = 1'b1;

    localparam logic StatusOk     = 1'b0;
    localparam logic StatusReject = 1'b1;

endpackage

`default_nettype wire

FILE: design/dic_mem.sv
// ----------------------------------------------------------------------------
// Dynamic inversion counter - synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dic_mem #(
    parameter int AW = 10,
    parameter int DW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/dic_walk.sv
// ----------------------------------------------------------------------------
// Dynamic inversion counter - Fenwick index walker
// Steps through the two-level Fenwick index chain, one cell per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dic_walk #(
    parameter int MAX_ELEMENTS = dic_pkg::DefMaxElements
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic                                i_add,
    input  wire logic [$clog2(MAX_ELEMENTS)+1:0]     i_p,
    input  wire logic [$clog2(MAX_ELEMENTS)+1:0]     i_v,
    output logic                                     o_rd_en,
    output logic [2*$clog2(MAX_ELEMENTS)-1:0]        o_addr,
    output logic                                     o_done
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = IW + 2;
    localparam logic [CW-1:0] MaxC = CW'(MAX_ELEMENTS);

    logic          r_busy;
    logic          r_add;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_j0;

    logic [CW-1:0] i_lb, j_lb, i_nx, j_nx;
    logic          i_end, j_end, empty;
    logic [CW-1:0] i_m1, j_m1;

    always_comb begin
        i_lb  = r_i & (~r_i + CW'(1));
        j_lb  = r_j & (~r_j + CW'(1));
        i_nx  = r_add ? (r_i + i_lb) : (r_i - i_lb);
        j_nx  = r_add ? (r_j + j_lb) : (r_j - j_lb);
        i_end = r_add ? (i_nx > MaxC) : (i_nx == '0);
        j_end = r_add ? (j_nx > MaxC) : (j_nx == '0);
        empty = (r_i == '0) || (r_j == '0);
        i_m1  = r_i - CW'(1);
        j_m1  = r_j - CW'(1);
    end

    assign o_rd_en = r_busy && !empty;
    assign o_done  = r_busy && (empty || (i_end && j_end));
    assign o_addr  = {i_m1[IW-1:0], j_m1[IW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_add <= i_add;
            r_i   <= i_p;
            r_j   <= i_v;
            r_j0  <= i_v;
        end else if (r_busy && !o_done) begin
            if (j_end) begin
                r_i <= i_nx;
                r_j <= r_j0;
            end else begin
                r_j <= j_nx;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/dynamic_inversion_counter.sv
// ----------------------------------------------------------------------------
// Dynamic inversion counter - top level
// Tracks the inversion count of a partial permutation under loads and deletes.
// ----------------------------------------------------------------------------
// After reset the block sweeps its Fenwick count RAM to zero, one entry per
// cycle; s_axis_tready stays low meanwhile, while the APB port works as
// usual. The block then takes one item at a time. An item goes through a
// value-table lookup and a check, then for each Fenwick walk a set-up state,
// a run state that visits the Fenwick cells and an end state. A load walks
// two prefix sums and one update, and a delete four prefix sums and one
// update. A prefix sum touches the product of the set-bit counts of its two
// indices, and an update up to (log2(MAX_ELEMENTS)+1)^2 cells, all through
// the single read port of the count RAM. Rejected items go from the check
// straight to the result. One result beat leaves per input beat; it sits in
// an output register, so the block keeps working while it waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module dynamic_inversion_counter #(
    parameter int MAX_ELEMENTS = dic_pkg::DefMaxElements
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input beats. tdata: value [10:0]; tuser: action [0].
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [dic_pkg::InDataW-1:0]   i_s_axis_tdata,
    input  wire logic [0:0]                    i_s_axis_tuser,
    // Result beats. tdata: inversions [18:0]; tuser: status [0].
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [dic_pkg::OutDataW-1:0]       o_m_axis_tdata,
    output logic [0:0]                         o_m_axis_tuser,
    // APB configuration port: n_size at byte address 0.
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [dic_pkg::ApbAddrW-1:0]  i_paddr,
    input  wire logic [31:0]                   i_pwdata,
    output logic [31:0]                        o_prdata,
    output logic                               o_pready
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = IW + 2;
    localparam int PW = $clog2(MAX_ELEMENTS + 1);
    localparam int FAW = 2 * IW;
    localparam logic [CW-1:0] MaxC = CW'(MAX_ELEMENTS);

    localparam logic [3:0] StClr  = 4'd0;
    localparam logic [3:0] StIdle = 4'd1;
    localparam logic [3:0] StLook = 4'd2;
    localparam logic [3:0] StChk  = 4'd3;
    localparam logic [3:0] StQGo  = 4'd4;
    localparam logic [3:0] StQRun = 4'd5;
    localparam logic [3:0] StQEnd = 4'd6;
    localparam logic [3:0] StAGo  = 4'd7;
    localparam logic [3:0] StARun = 4'd8;
    localparam logic [3:0] StAEnd = 4'd9;
    localparam logic [3:0] StRes  = 4'd10;

    // Control state.
    logic [3:0]                  r_state;
    logic [FAW-1:0]              r_clr;
    logic [dic_pkg::SizeW-1:0]   r_n_size;
    logic [PW-1:0]               r_loaded;
    logic [dic_pkg::TotalW-1:0]  r_total;
    logic                        r_out_vld;
    logic [1:0]                  r_phase;
    logic                        r_rd_vld;
    logic                        r_upd_vld;

    // Item payload registers.
    logic                        r_act;
    logic [dic_pkg::ValueW-1:0]  r_val;
    logic [CW-1:0]               r_pos;
    logic                        r_ok;
    logic [dic_pkg::TotalW-1:0]  r_acc;
    logic [dic_pkg::InvW-1:0]    r_report;
    logic [dic_pkg::InvW-1:0]    r_out_inv;
    logic                        r_out_st;
    logic [FAW-1:0]              r_upd_addr;

    // Configuration port. Software must write it only while no item is in flight; the block does not enforce this.
    logic cfg_wr;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready
                      && (i_paddr == dic_pkg::RegNSize);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == dic_pkg::RegNSize) ? 32'(r_n_size) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_size <= dic_pkg::SizeReset;
        end else if (cfg_wr) begin
            r_n_size <= i_pwdata[dic_pkg::SizeW-1:0];
        end
    end

    // Effective size is the register capped at the store's span.
    logic [CW-1:0] n_eff;
    logic          v_in_range;
    assign n_eff = (32'(r_n_size) < MAX_ELEMENTS) ? CW'(r_n_size) : MaxC;
    assign v_in_range = (r_val != '0) && (32'(r_val) <= 32'(n_eff));

    // Value table: {present, position} per value, with registered read data.
    logic [PW:0]   vt_q;
    logic          vt_we;
    logic [IW-1:0] vt_waddr, vt_raddr;
    logic [PW:0]   vt_wdata;
    logic [dic_pkg::ValueW-1:0] val_m1;

    assign val_m1   = r_val - dic_pkg::ValueW'(1);
    assign vt_raddr = val_m1[IW-1:0];

    // Item check, valid in the lookup-result cycle.
    logic          present;
    logic          ok_now;
    logic [CW-1:0] load_pos;
    assign present  = vt_q[PW];
    assign load_pos = CW'(r_loaded) + CW'(1);
    always_comb begin
        if (r_act == dic_pkg::ActLoad) begin
            ok_now = v_in_range && !present && (CW'(r_loaded) < n_eff);
        end else begin
            ok_now = v_in_range && present;
        end
    end

    always_comb begin
        vt_we    = 1'b0;
        vt_waddr = vt_raddr;
        vt_wdata = '0;
        if (r_state == StClr) begin
            vt_we    = 1'b1;
            vt_waddr = r_clr[IW-1:0];
        end else if (r_state == StChk && ok_now) begin
            vt_we    = 1'b1;
            vt_wdata = (r_act == dic_pkg::ActLoad) ? {1'b1, load_pos[PW-1:0]}
                                                   : {1'b0, vt_q[PW-1:0]};
        end
    end

    dic_mem #(.AW(IW), .DW(PW + 1)) u_vtab (
        .i_clk   (i_clk),
        .i_we    (vt_we),
        .i_waddr (vt_waddr),
        .i_wdata (vt_wdata),
        .i_re    (1'b1),
        .i_raddr (vt_raddr),
        .o_rdata (vt_q)
    );

    // Query phase parameters. A load adds sum(p-1,all) - sum(p-1,v); a
    // delete removes the earlier larger and later smaller pairs, i.e. adds
    // -sum(p-1,all) + sum(p-1,v) - sum(all,v-1) + sum(p,v-1).
    logic [CW-1:0] v_c, q_p, q_v;
    logic          q_neg, q_last;
    assign v_c = CW'(r_val);
    always_comb begin
        q_p = r_pos - CW'(1);
        q_v = MaxC;
        case (r_phase)
            2'd0: begin
                q_p = r_pos - CW'(1);
                q_v = MaxC;
            end
            2'd1: begin
                q_p = r_pos - CW'(1);
                q_v = v_c;
            end
            2'd2: begin
                q_p = MaxC;
                q_v = v_c - CW'(1);
            end
            default: begin
                q_p = r_pos;
                q_v = v_c - CW'(1);
            end
        endcase
        q_neg  = r_phase[0] ^ (r_act == dic_pkg::ActDelete);
        q_last = (r_act == dic_pkg::ActLoad) ? (r_phase == 2'd1) : (r_phase == 2'd3);
    end

    // Fenwick walker and count RAM.
    logic           w_start, w_add, w_rd_en, w_done;
    logic [CW-1:0]  w_p, w_v;
    logic [FAW-1:0] w_addr;
    assign w_start = (r_state == StQGo) || (r_state == StAGo);
    assign w_add   = (r_state == StAGo);
    assign w_p     = w_add ? r_pos : q_p;
    assign w_v     = w_add ? v_c : q_v;

    dic_walk #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_add   (w_add),
        .i_p     (w_p),
        .i_v     (w_v),
        .o_rd_en (w_rd_en),
        .o_addr  (w_addr),
        .o_done  (w_done)
    );

    logic [PW-1:0]  fw_q;
    logic           fw_we;
    logic [FAW-1:0] fw_waddr;
    logic [PW-1:0]  fw_wdata;
    // Update cells are read, then written back in the cycle after; the cells
    // of one update are all distinct, so no read meets a pending write.
    always_comb begin
        if (r_state == StClr) begin
            fw_we    = 1'b1;
            fw_waddr = r_clr;
            fw_wdata = '0;
        end else begin
            fw_we    = r_upd_vld;
            fw_waddr = r_upd_addr;
            fw_wdata = (r_act == dic_pkg::ActDelete) ? (fw_q - PW'(1)) : (fw_q + PW'(1));
        end
    end

    dic_mem #(.AW(FAW), .DW(PW)) u_fw (
        .i_clk   (i_clk),
        .i_we    (fw_we),
        .i_waddr (fw_waddr),
        .i_wdata (fw_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_addr),
        .o_rdata (fw_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_upd_vld <= 1'b0;
        end else begin
            r_rd_vld  <= w_rd_en && (r_state != StARun);
            r_upd_vld <= w_rd_en && (r_state == StARun);
        end
    end

    always_ff @(posedge i_clk) begin
        r_upd_addr <= w_addr;
    end

    // Handshakes.
    logic in_acc, out_free;
    assign o_s_axis_tready = (r_state == StIdle);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = dic_pkg::OutDataW'(r_out_inv);
    assign o_m_axis_tuser  = r_out_st;

    // Sequencer.
    logic [3:0] n_state;
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            StClr:  n_state = (r_clr == '1) ? StIdle : StClr;
            StIdle: n_state = in_acc ? StLook : StIdle;
            StLook: n_state = StChk;
            StChk:  n_state = ok_now ? StQGo : StRes;
            StQGo:  n_state = StQRun;
            StQRun: n_state = w_done ? StQEnd : StQRun;
            StQEnd: n_state = q_last ? StAGo : StQGo;
            StAGo:  n_state = StARun;
            StARun: n_state = w_done ? StAEnd : StARun;
            StAEnd: n_state = StRes;
            StRes:  n_state = out_free ? StIdle : StRes;
            default: n_state = StClr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= StClr;
            r_clr     <= '0;
            r_loaded  <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
            r_phase   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == StClr) begin
                r_clr <= r_clr + FAW'(1);
            end
            if (r_state == StChk && ok_now && r_act == dic_pkg::ActLoad) begin
                r_loaded <= r_loaded + PW'(1);
            end
            if (r_state == StChk) begin
                r_phase <= 2'd0;
            end else if (r_state == StQEnd) begin
                r_phase <= r_phase + 2'd1;
            end
            if (r_state == StAGo) begin
                r_total <= r_total + r_acc;
            end
            if (r_state == StRes && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act <= i_s_axis_tuser[0];
            r_val <= i_s_axis_tdata[dic_pkg::ValueW-1:0];
        end
        if (r_state == StChk) begin
            r_ok     <= ok_now;
            r_acc    <= '0;
            r_report <= r_total[dic_pkg::InvW-1:0];
            r_pos    <= (r_act == dic_pkg::ActLoad) ? load_pos : CW'(vt_q[PW-1:0]);
        end
        if (r_rd_vld) begin
            r_acc <= q_neg ? (r_acc - dic_pkg::TotalW'(fw_q))
                           : (r_acc + dic_pkg::TotalW'(fw_q));
        end
        if (r_state == StAGo && r_act == dic_pkg::ActLoad) begin
            r_report <= dic_pkg::InvW'(r_total + r_acc);
        end
        if (r_state == StRes && out_free) begin
            r_out_inv <= r_report;
            r_out_st  <= r_ok ? dic_pkg::StatusOk : dic_pkg::StatusReject;
        end
    end

endmodule

`default_nettype wire

FILE: design/dic_checker.sv
// ----------------------------------------------------------------------------
// Dynamic inversion counter - port checker
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dynamic_inversion_counter_assert.svh"

module dic_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_axis_tvalid,
    input wire logic                          o_s_axis_tready,
    input wire logic [dic_pkg::InDataW-1:0]   i_s_axis_tdata,
    input wire logic [0:0]                    i_s_axis_tuser,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [dic_pkg::OutDataW-1:0]  o_m_axis_tdata,
    input wire logic [0:0]                    o_m_axis_tuser,
    input wire logic                          o_pready
);

    logic in_acc;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // The configuration port never waits.
    `DIC_ASSERT_ALWAYS(a_pready_high, i_clk, o_pready, "pready dropped")

    // The count RAM is swept after reset, so no beat is taken straight away.
    `DIC_ASSERT_IMPL(a_clear_after_reset, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_s_axis_tready, "ready during clearing sweep")

    // One item at a time: taking a beat closes the input side.
    `DIC_ASSERT_IMPL(a_one_item, i_clk, i_rst_n, in_acc |=> !o_s_axis_tready, "second beat taken while busy")

    // A stalled result beat holds its payload.
    `DIC_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed while stalled")

endmodule

bind dynamic_inversion_counter dic_checker u_dic_checker (.*);

`default_nettype wire
